### rtl/core/fcde_pkg.sv
// ----------------------------------------------------------------------------
// fcde_pkg
// shared constants and types of the fitted curve derivative evaluator
// ----------------------------------------------------------------------------
package fcde_pkg;

	localparam int DATA_W    = 32;
	localparam int MUL_CHUNK = 32;
	localparam int MUL_LAT   = 4;
	localparam int QUO_W     = DATA_W + 1;
	localparam int DIV_LAT   = QUO_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int N_OUT     = 5;

	localparam logic [CFG_IDX_W-1:0] REG_MODEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_E = 3'd5;

	typedef enum logic [1:0] {
		MODEL_RATIONAL = 2'd0,
		MODEL_POLY     = 2'd1,
		MODEL_CAUCHY   = 2'd2
	} model_t;

endpackage

### rtl/core/fcde_mul.sv
// ----------------------------------------------------------------------------
// fcde_mul
// pipelined signed multiplier built from 32x32 partial products, four stages
// ----------------------------------------------------------------------------
module fcde_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int CW  = fcde_pkg::MUL_CHUNK;
	localparam int NA  = (AW + CW - 1) / CW;
	localparam int NB  = (BW + CW - 1) / CW;
	localparam int AP  = NA * CW;
	localparam int BP  = NB * CW;
	localparam int RWD = BP + CW;
	localparam int SW  = AP + BP;

	logic [AW-1:0]     aa;
	logic [BW-1:0]     ab;
	logic [AP-1:0]     am_s1;
	logic [BP-1:0]     bm_s1;
	logic              neg_s1, neg_s2, neg_s3;
	logic [2*CW-1:0]   pp_s2 [NA][NB];
	logic [RWD-1:0]    row_c [NA];
	logic [RWD-1:0]    row_s3 [NA];
	logic [SW-1:0]     sum_c;
	logic [AW+BW-1:0]  p_s4;

	always_comb begin
		aa = a[AW-1] ? -a : a;
		ab = b[BW-1] ? -b : b;
	end

	always_ff @(posedge clk) begin
		am_s1  <= AP'(aa);
		bm_s1  <= BP'(ab);
		neg_s1 <= a[AW-1] ^ b[BW-1];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s2[i][j] <= (2*CW)'(am_s1[i*CW +: CW]) * (2*CW)'(bm_s1[j*CW +: CW]);
			end
		end
		neg_s2 <= neg_s1;
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RWD'(pp_s2[i][j]) << (CW*j));
			end
		end
	end

	always_ff @(posedge clk) begin
		row_s3 <= row_c;
		neg_s3 <= neg_s2;
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (SW'(row_s3[i]) << (CW*i));
		end
	end

	always_ff @(posedge clk) begin
		p_s4 <= (AW+BW)'(neg_s3 ? -sum_c : sum_c);
	end

	assign p = p_s4;

endmodule

### rtl/core/fcde_div.sv
// ----------------------------------------------------------------------------
// fcde_div
// pipelined restoring divider giving floor(2n/d) to 33 bits and an overflow
// ----------------------------------------------------------------------------
module fcde_div #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  logic                         clk,
	input  logic [NW-1:0]                num,
	input  logic [DW-1:0]                den,
	output logic [fcde_pkg::QUO_W-1:0]   quo,
	output logic                         ovf
);

	localparam int QB   = fcde_pkg::QUO_W;
	localparam int RW   = DW + QB + 1;
	localparam int CMPW = (NW + 1 > DW + QB) ? NW + 1 : DW + QB;

	logic [RW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic          ovf_s [QB+1];

	always_ff @(posedge clk) begin
		ovf_s[0] <= (CMPW'(num) << 1) >= (CMPW'(den) << QB);
		rem_s[0] <= RW'(num) << 1;
		den_s[0] <= den;
		quo_s[0] <= '0;
	end

	for (genvar j = 1; j <= QB; j++) begin : g_step
		localparam int K = QB - j;
		logic [RW-1:0] dsh;
		assign dsh = RW'(den_s[j-1]) << K;
		always_ff @(posedge clk) begin
			if (rem_s[j-1] >= dsh) begin
				rem_s[j] <= rem_s[j-1] - dsh;
				quo_s[j] <= quo_s[j-1] | (QB'(1) << K);
			end else begin
				rem_s[j] <= rem_s[j-1];
				quo_s[j] <= quo_s[j-1];
			end
			den_s[j] <= den_s[j-1];
			ovf_s[j] <= ovf_s[j-1];
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];

endmodule

### rtl/core/fitted_curve_derivative_evaluator_core.sv
// ----------------------------------------------------------------------------
// fitted_curve_derivative_evaluator_core
// curve value, slope, curvature and their reciprocals of a fitted curve
// ----------------------------------------------------------------------------
// One position word is taken in every clock cycle; busy is always low. Each
// result word appears on the result ports with done high for one cycle, in
// order and without gaps beyond those of the input. The depth comes from four
// layers of four-stage multipliers and the 34-stage restoring dividers, one
// per output. Write the model and coefficient registers only while no
// position is in flight.
module fitted_curve_derivative_evaluator_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [fcde_pkg::DATA_W-1:0]     x_pos,
	input  logic                                   cfg_we,
	input  logic [fcde_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fcde_pkg::DATA_W-1:0]            cfg_data,
	output logic                                   done,
	output logic signed [fcde_pkg::DATA_W-1:0]     curve_value,
	output logic signed [fcde_pkg::DATA_W-1:0]     slope,
	output logic signed [fcde_pkg::DATA_W-1:0]     curvature,
	output logic signed [fcde_pkg::DATA_W-1:0]     inv_slope,
	output logic signed [fcde_pkg::DATA_W-1:0]     inv_curvature,
	output logic [fcde_pkg::N_OUT-1:0]             zero_div_flags,
	output logic [fcde_pkg::N_OUT-1:0]             saturate_flags
);

	localparam int W    = fcde_pkg::DATA_W;
	localparam int F    = FRAC_BITS;
	localparam int ML   = fcde_pkg::MUL_LAT;
	localparam int DL   = fcde_pkg::DIV_LAT;
	localparam int QB   = fcde_pkg::QUO_W;
	localparam int NO   = fcde_pkg::N_OUT;
	localparam int PW2  = 2 * W;
	localparam int PW3  = 3 * W;
	localparam int QW   = 3 * W + 2;
	localparam int N1W  = 2 * W + 2;
	localparam int N2W  = W + 2;
	localparam int PW   = N1W + QW + 1;
	localparam int TW   = N2W + QW + 1;
	localparam int SQW  = 2 * QW;
	localparam int HW   = TW + QW + 2;
	localparam int CUW  = SQW + QW;
	localparam int C1W  = 4 * PW2;
	localparam int C2W  = 2 * QW + N1W;
	localparam int C3W  = 2 * QW + PW + SQW;
	localparam int LAST = 4 * ML + DL + 5;
	localparam logic signed [W-1:0] ONE_FX = W'(1) << F;

	fcde_pkg::model_t    model_q;
	logic signed [W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, coef_e_q;
	logic [LAST:0]       vld_q;

	logic signed [W-1:0] n2_c, n1_c, n0_c, m2_c, m1_c, m0_c;
	logic signed [N2W-1:0] n2c, m2c;
	logic                  model_ok;

	logic signed [W-1:0]   x_s1;
	logic signed [PW2-1:0] x2_p, n1x_p, m1x_p, n2x_p, m2x_p;
	logic signed [PW3-1:0] n2x2_p, m2x2_p;
	logic [C1W-1:0]        c1_q [ML];
	logic signed [PW2-1:0] n1x_d, m1x_d, n2x_d, m2x_d;

	logic signed [QW-1:0]  ni_s2, mi_s2;
	logic signed [N1W-1:0] n1i_s2, m1i_s2;
	logic signed [N1W+QW-1:0] a1_p, a2_p;
	logic signed [N2W+QW-1:0] a3_p, a4_p;
	logic signed [SQW-1:0] msq_p;
	logic [C2W-1:0]        c2_q [ML];

	logic signed [PW-1:0]  p_s3;
	logic signed [TW-1:0]  t_s3;
	logic signed [SQW-1:0] sq_s3;
	logic signed [QW-1:0]  ni_s3, mi_s3;
	logic signed [N1W-1:0] m1i_s3;
	logic signed [TW+QW-1:0] b1_p, b2_p;
	logic signed [CUW-1:0] mc_p;
	logic [C3W-1:0]        c3_q [ML];

	logic signed [HW-1:0]  h_s4;
	logic signed [CUW-1:0] cu_s4;
	logic signed [QW-1:0]  ni_s4, mi_s4;
	logic signed [PW-1:0]  p_s4;
	logic signed [SQW-1:0] sq_s4;

	logic [QW-1:0]  ani, ami;
	logic [PW-1:0]  ap;
	logic [HW-1:0]  ah;
	logic [CUW-1:0] acu;
	logic [SQW-1:0] usq;

	logic [QW+F-1:0]   dn0_s5;
	logic [QW-1:0]     dd0_s5;
	logic [PW+2*F-1:0] dn1_s5;
	logic [SQW-1:0]    dd1_s5;
	logic [HW+3*F-1:0] dn2_s5;
	logic [CUW-1:0]    dd2_s5;
	logic [SQW-1:0]    dn3_s5;
	logic [PW-1:0]     dd3_s5;
	logic [CUW-1:0]    dn4_s5;
	logic [HW+F-1:0]   dd4_s5;
	logic [NO-1:0]     zr_s5, ng_s5;
	logic [2*NO-1:0]   flg_q [DL];

	logic [QB-1:0]     quo_w [NO];
	logic              ovf_w [NO];
	logic [NO-1:0]     zr_d, ng_d;

	logic signed [W-1:0] val_c [NO];
	logic [NO-1:0]       zf_c, sf_c;
	logic signed [W-1:0] val_s6 [NO];
	logic [NO-1:0]       zf_s6, sf_s6;

	logic [QB:0]   rnd, lim;
	logic          sat;
	logic [W-1:0]  mag;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q  <= fcde_pkg::MODEL_RATIONAL;
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			coef_d_q <= '0;
			coef_e_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcde_pkg::REG_MODEL:  model_q  <= fcde_pkg::model_t'(cfg_data[1:0]);
				fcde_pkg::REG_COEF_A: coef_a_q <= cfg_data;
				fcde_pkg::REG_COEF_B: coef_b_q <= cfg_data;
				fcde_pkg::REG_COEF_C: coef_c_q <= cfg_data;
				fcde_pkg::REG_COEF_D: coef_d_q <= cfg_data;
				fcde_pkg::REG_COEF_E: coef_e_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAST-1:0], start & ~busy};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LAST];

	// numerator n2 x^2 + n1 x + n0 over denominator m2 x^2 + m1 x + m0
	always_comb begin
		n2_c = coef_a_q;
		n1_c = coef_b_q;
		n0_c = coef_c_q;
		m2_c = ONE_FX;
		m1_c = coef_d_q;
		m0_c = coef_e_q;
		model_ok = 1'b1;
		unique case (model_q)
			fcde_pkg::MODEL_RATIONAL: ;
			fcde_pkg::MODEL_POLY: begin
				m2_c = '0;
				m1_c = '0;
				m0_c = ONE_FX;
			end
			fcde_pkg::MODEL_CAUCHY: begin
				n2_c = '0;
				n1_c = '0;
				n0_c = ONE_FX;
				m2_c = coef_a_q;
				m1_c = coef_b_q;
				m0_c = coef_c_q;
			end
			default: model_ok = 1'b0;
		endcase
	end

	assign n2c = N2W'(n2_c) <<< 1;
	assign m2c = N2W'(m2_c) <<< 1;

	always_ff @(posedge clk) begin
		x_s1 <= x_pos;
	end

	fcde_mul #(.AW(W), .BW(W)) u_mul_x2  (.clk(clk), .a(x_s1), .b(x_s1), .p(x2_p));
	fcde_mul #(.AW(W), .BW(W)) u_mul_n1x (.clk(clk), .a(n1_c), .b(x_s1), .p(n1x_p));
	fcde_mul #(.AW(W), .BW(W)) u_mul_m1x (.clk(clk), .a(m1_c), .b(x_s1), .p(m1x_p));
	fcde_mul #(.AW(W), .BW(W)) u_mul_n2x (.clk(clk), .a(n2_c), .b(x_s1), .p(n2x_p));
	fcde_mul #(.AW(W), .BW(W)) u_mul_m2x (.clk(clk), .a(m2_c), .b(x_s1), .p(m2x_p));

	fcde_mul #(.AW(W), .BW(PW2)) u_mul_n2x2 (.clk(clk), .a(n2_c), .b(x2_p), .p(n2x2_p));
	fcde_mul #(.AW(W), .BW(PW2)) u_mul_m2x2 (.clk(clk), .a(m2_c), .b(x2_p), .p(m2x2_p));

	always_ff @(posedge clk) begin
		c1_q[0] <= {n1x_p, m1x_p, n2x_p, m2x_p};
		for (int i = 1; i < ML; i++) begin
			c1_q[i] <= c1_q[i-1];
		end
	end

	assign n1x_d = c1_q[ML-1][4*PW2-1 -: PW2];
	assign m1x_d = c1_q[ML-1][3*PW2-1 -: PW2];
	assign n2x_d = c1_q[ML-1][2*PW2-1 -: PW2];
	assign m2x_d = c1_q[ML-1][PW2-1:0];

	// polynomials and first derivatives
	always_ff @(posedge clk) begin
		ni_s2  <= QW'(n2x2_p) + (QW'(n1x_d) <<< F) + (QW'(n0_c) <<< (2*F));
		mi_s2  <= QW'(m2x2_p) + (QW'(m1x_d) <<< F) + (QW'(m0_c) <<< (2*F));
		n1i_s2 <= (N1W'(n2x_d) <<< 1) + (N1W'(n1_c) <<< F);
		m1i_s2 <= (N1W'(m2x_d) <<< 1) + (N1W'(m1_c) <<< F);
	end

	fcde_mul #(.AW(N1W), .BW(QW)) u_mul_a1 (.clk(clk), .a(n1i_s2), .b(mi_s2), .p(a1_p));
	fcde_mul #(.AW(QW), .BW(N1W)) u_mul_a2 (.clk(clk), .a(ni_s2), .b(m1i_s2), .p(a2_p));
	fcde_mul #(.AW(N2W), .BW(QW)) u_mul_a3 (.clk(clk), .a(n2c), .b(mi_s2), .p(a3_p));
	fcde_mul #(.AW(QW), .BW(N2W)) u_mul_a4 (.clk(clk), .a(ni_s2), .b(m2c), .p(a4_p));
	fcde_mul #(.AW(QW), .BW(QW))  u_mul_sq (.clk(clk), .a(mi_s2), .b(mi_s2), .p(msq_p));

	always_ff @(posedge clk) begin
		c2_q[0] <= {ni_s2, mi_s2, m1i_s2};
		for (int i = 1; i < ML; i++) begin
			c2_q[i] <= c2_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		p_s3   <= PW'(a1_p) - PW'(a2_p);
		t_s3   <= TW'(a3_p) - TW'(a4_p);
		sq_s3  <= msq_p;
		ni_s3  <= c2_q[ML-1][C2W-1 -: QW];
		mi_s3  <= c2_q[ML-1][N1W+QW-1 -: QW];
		m1i_s3 <= c2_q[ML-1][N1W-1:0];
	end

	fcde_mul #(.AW(TW), .BW(QW))  u_mul_b1 (.clk(clk), .a(t_s3), .b(mi_s3), .p(b1_p));
	fcde_mul #(.AW(N1W), .BW(PW)) u_mul_b2 (.clk(clk), .a(m1i_s3), .b(p_s3), .p(b2_p));
	fcde_mul #(.AW(SQW), .BW(QW)) u_mul_cu (.clk(clk), .a(sq_s3), .b(mi_s3), .p(mc_p));

	always_ff @(posedge clk) begin
		c3_q[0] <= {ni_s3, mi_s3, p_s3, sq_s3};
		for (int i = 1; i < ML; i++) begin
			c3_q[i] <= c3_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		h_s4  <= HW'(b1_p) - (HW'(b2_p) <<< 1);
		cu_s4 <= mc_p;
		ni_s4 <= c3_q[ML-1][C3W-1 -: QW];
		mi_s4 <= c3_q[ML-1][C3W-QW-1 -: QW];
		p_s4  <= c3_q[ML-1][PW+SQW-1 -: PW];
		sq_s4 <= c3_q[ML-1][SQW-1:0];
	end

	// magnitudes, signs and zero divisors
	always_comb begin
		ani = ni_s4[QW-1] ? -ni_s4 : ni_s4;
		ami = mi_s4[QW-1] ? -mi_s4 : mi_s4;
		ap  = p_s4[PW-1] ? -p_s4 : p_s4;
		ah  = h_s4[HW-1] ? -h_s4 : h_s4;
		acu = cu_s4[CUW-1] ? -cu_s4 : cu_s4;
		usq = sq_s4;
	end

	always_ff @(posedge clk) begin
		dn0_s5 <= (QW+F)'(ani) << F;
		dd0_s5 <= ami;
		dn1_s5 <= (PW+2*F)'(ap) << (2*F);
		dd1_s5 <= usq;
		dn2_s5 <= (HW+3*F)'(ah) << (3*F);
		dd2_s5 <= acu;
		dn3_s5 <= usq;
		dd3_s5 <= ap;
		dn4_s5 <= acu;
		dd4_s5 <= (HW+F)'(ah) << F;
		zr_s5  <= {h_s4 == '0, p_s4 == '0, cu_s4 == '0, sq_s4 == '0, mi_s4 == '0};
		ng_s5  <= {(cu_s4[CUW-1] ^ h_s4[HW-1]) & (cu_s4 != '0),
		           p_s4[PW-1] & (sq_s4 != '0),
		           (h_s4[HW-1] ^ cu_s4[CUW-1]) & (h_s4 != '0),
		           p_s4[PW-1] & (p_s4 != '0),
		           (ni_s4[QW-1] ^ mi_s4[QW-1]) & (ni_s4 != '0)};
	end

	fcde_div #(.NW(QW+F), .DW(QW)) u_div_val (
		.clk(clk), .num(dn0_s5), .den(dd0_s5), .quo(quo_w[0]), .ovf(ovf_w[0]));
	fcde_div #(.NW(PW+2*F), .DW(SQW)) u_div_slope (
		.clk(clk), .num(dn1_s5), .den(dd1_s5), .quo(quo_w[1]), .ovf(ovf_w[1]));
	fcde_div #(.NW(HW+3*F), .DW(CUW)) u_div_curv (
		.clk(clk), .num(dn2_s5), .den(dd2_s5), .quo(quo_w[2]), .ovf(ovf_w[2]));
	fcde_div #(.NW(SQW), .DW(PW)) u_div_islope (
		.clk(clk), .num(dn3_s5), .den(dd3_s5), .quo(quo_w[3]), .ovf(ovf_w[3]));
	fcde_div #(.NW(CUW), .DW(HW+F)) u_div_icurv (
		.clk(clk), .num(dn4_s5), .den(dd4_s5), .quo(quo_w[4]), .ovf(ovf_w[4]));

	always_ff @(posedge clk) begin
		flg_q[0] <= {ng_s5, zr_s5};
		for (int i = 1; i < DL; i++) begin
			flg_q[i] <= flg_q[i-1];
		end
	end

	assign ng_d = flg_q[DL-1][2*NO-1:NO];
	assign zr_d = flg_q[DL-1][NO-1:0];

	// round half away from zero, then clip
	always_comb begin
		rnd = '0;
		lim = '0;
		sat = 1'b0;
		mag = '0;
		for (int i = 0; i < NO; i++) begin
			rnd = ((QB+1)'(quo_w[i]) + (QB+1)'(1)) >> 1;
			lim = (QB+1)'({1'b0, {(W-1){1'b1}}}) + (QB+1)'(ng_d[i]);
			sat = ovf_w[i] | (rnd > lim);
			mag = sat ? lim[W-1:0] : rnd[W-1:0];
			val_c[i] = ng_d[i] ? -mag : mag;
			zf_c[i] = zr_d[i];
			sf_c[i] = sat & ~zr_d[i];
			if (zr_d[i] || !model_ok) begin
				val_c[i] = '0;
			end
			if (!model_ok) begin
				zf_c[i] = 1'b0;
				sf_c[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_s6 <= val_c;
		zf_s6  <= zf_c;
		sf_s6  <= sf_c;
	end

	assign curve_value    = val_s6[0];
	assign slope          = val_s6[1];
	assign curvature      = val_s6[2];
	assign inv_slope      = val_s6[3];
	assign inv_curvature  = val_s6[4];
	assign zero_div_flags = zf_s6;
	assign saturate_flags = sf_s6;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fitted curve derivative evaluator. Each position
// word is predicted with exact wide-integer arithmetic for the active model
// unless typed in the table, which runs first; then fixed and random curves.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int PIPE_WAIT = 60;
	localparam logic [1:0] MODEL_UNUSED = 2'd3;

	typedef logic signed [383:0] wide_t;
	typedef logic [383:0] uwide_t;

	typedef struct packed {
		logic [31:0] curve_value;
		logic [31:0] slope;
		logic [31:0] curvature;
		logic [31:0] inv_slope;
		logic [31:0] inv_curvature;
		logic [4:0]  zf;
		logic [4:0]  sf;
	} curve_word_t;

	typedef struct packed {
		logic [1:0]  model;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		logic [31:0] x;
		bit          typed;
		curve_word_t want;
	} stim_row_t;

	localparam int N_ROWS = 15;
	localparam curve_word_t ZW = '0;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{fcde_pkg::MODEL_RATIONAL, 0, 0, 0, 0, 0, 32'h0, 1'b1,
			'{0, 0, 0, 0, 0, 5'h1f, 5'h00}},
		'{fcde_pkg::MODEL_RATIONAL, 0, 0, 0, 0, 0, 32'h7fffffff, 1'b0, ZW},
		'{fcde_pkg::MODEL_RATIONAL, 0, 0, 0, 0, 0, 32'h80000000, 1'b0, ZW},
		'{MODEL_UNUSED, 32'h7fffffff, 32'h80000000, 32'h00010000, 32'h1, 32'hffffffff,
			32'h12345678, 1'b1, ZW},
		'{fcde_pkg::MODEL_POLY, 0, 0, 0, 0, 0, 32'h7fffffff, 1'b1,
			'{0, 0, 0, 0, 0, 5'h18, 5'h00}},
		'{fcde_pkg::MODEL_POLY, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 1'b1,
			'{32'h7fffffff, 0, 0, 0, 0, 5'h18, 5'h00}},
		'{fcde_pkg::MODEL_POLY, 32'h1, 0, 0, 0, 0, 32'h0, 1'b1,
			'{0, 0, 32'h2, 0, 32'h7fffffff, 5'h08, 5'h10}},
		'{fcde_pkg::MODEL_POLY, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0,
			32'h7fffffff, 1'b0, ZW},
		'{fcde_pkg::MODEL_CAUCHY, 0, 0, 32'h00010000, 0, 0, 32'h00050000, 1'b1,
			'{32'h00010000, 0, 0, 0, 0, 5'h18, 5'h00}},
		'{fcde_pkg::MODEL_CAUCHY, 0, 0, 0, 0, 0, 32'h0, 1'b0, ZW},
		'{fcde_pkg::MODEL_CAUCHY, 32'h00010000, 0, 32'h00010000, 0, 0, 32'h00010000,
			1'b0, ZW},
		'{fcde_pkg::MODEL_RATIONAL, 32'h00010000, 0, 0, 0, 32'h00010000, 32'h00008000,
			1'b0, ZW},
		'{fcde_pkg::MODEL_RATIONAL, 32'h1, 32'h2, 32'h3, 32'hfffe0000, 32'h00010000,
			32'h00010000, 1'b0, ZW},
		'{fcde_pkg::MODEL_RATIONAL, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h80000000, 1'b0, ZW},
		'{fcde_pkg::MODEL_CAUCHY, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0,
			32'h7fffffff, 1'b0, ZW}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic signed [fcde_pkg::DATA_W-1:0] x_pos;
	logic        cfg_we;
	logic [fcde_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fcde_pkg::DATA_W-1:0] cfg_data;
	logic        done;
	logic signed [fcde_pkg::DATA_W-1:0] curve_value, slope, curvature, inv_slope;
	logic signed [fcde_pkg::DATA_W-1:0] inv_curvature;
	logic [fcde_pkg::N_OUT-1:0] zero_div_flags, saturate_flags;

	fitted_curve_derivative_evaluator_core #(.FRAC_BITS(FRAC)) dut (.*);

	curve_word_t pending_words[$];
	int          errors = 0;
	int          burst_left = 0;
	logic [1:0]  cur_model;
	logic [31:0] cur_a, cur_b, cur_c, cur_d, cur_e;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic round_field(input wide_t num, input int kn, input wide_t den,
			input int kd, input int idx, inout curve_word_t w);
		int      sh;
		bit      neg;
		uwide_t  nm, dm, q, r;
		logic [31:0] lim, mag, v;
		sh = kd + 1 - kn;
		if (sh >= 0)
			num = num <<< (sh * FRAC);
		else
			den = den <<< (-sh * FRAC);
		v = '0;
		if (den == 0) begin
			w.zf[idx] = 1'b1;
		end else begin
			neg = (num < 0) != (den < 0);
			nm = (num < 0) ? uwide_t'(-num) : uwide_t'(num);
			dm = (den < 0) ? uwide_t'(-den) : uwide_t'(den);
			q = nm / dm;
			r = nm % dm;
			if ((r << 1) >= dm)
				q = q + 1;
			if (num == 0)
				neg = 1'b0;
			lim = neg ? 32'h80000000 : 32'h7fffffff;
			if (q <= uwide_t'(lim)) begin
				mag = q[31:0];
			end else begin
				mag = lim;
				w.sf[idx] = 1'b1;
			end
			v = neg ? -mag : mag;
		end
		case (idx)
			0: w.curve_value = v;
			1: w.slope = v;
			2: w.curvature = v;
			3: w.inv_slope = v;
			default: w.inv_curvature = v;
		endcase
	endtask

	task automatic predict_curve(input logic [31:0] xr, output curve_word_t w);
		wide_t X, A, B, C, D, E, one, x2, x3, f, g, h, u, k, d1, d2, d3;
		X = signed'(xr);
		A = signed'(cur_a);
		B = signed'(cur_b);
		C = signed'(cur_c);
		D = signed'(cur_d);
		E = signed'(cur_e);
		one = 1;
		x2 = X * X;
		x3 = x2 * X;
		w = '0;
		case (cur_model)
			fcde_pkg::MODEL_RATIONAL: begin
				f = A * x2 + ((B * X) <<< FRAC) + (C <<< (2 * FRAC));
				d1 = x2 + D * X + (E <<< FRAC);
				round_field(f, 3, d1, 2, 0, w);
				g = A * D - (B <<< FRAC);
				h = 2 * (A * E - (C <<< FRAC));
				u = B * E - C * D;
				f = g * x2 + ((h * X) <<< FRAC) + (u <<< (2 * FRAC));
				d2 = d1 * d1;
				round_field(f, 4, d2, 4, 1, w);
				round_field(d2, 4, f, 4, 3, w);
				k = ((C * E) <<< FRAC) + B * D * E - C * D * D - A * E * E;
				k = (2 * k) <<< (2 * FRAC);
				k = k + (2 * g) * x3 + (((3 * h) * x2) <<< FRAC)
					+ (((6 * u) * X) <<< (2 * FRAC));
				f = -k;
				d3 = d2 * d1;
				round_field(f, 5, d3, 6, 2, w);
				round_field(d3, 6, f, 5, 4, w);
			end
			fcde_pkg::MODEL_POLY: begin
				f = A * x2 + ((B * X) <<< FRAC) + (C <<< (2 * FRAC));
				round_field(f, 3, one, 0, 0, w);
				g = 2 * A * X + (B <<< FRAC);
				round_field(g, 2, one, 0, 1, w);
				round_field(one, 0, g, 2, 3, w);
				h = 2 * A;
				round_field(h, 1, one, 0, 2, w);
				round_field(one, 0, h, 1, 4, w);
			end
			fcde_pkg::MODEL_CAUCHY: begin
				d1 = A * x2 + ((B * X) <<< FRAC) + (C <<< (2 * FRAC));
				round_field(one, 0, d1, 3, 0, w);
				g = -(2 * A * X + (B <<< FRAC));
				d2 = d1 * d1;
				round_field(g, 2, d2, 6, 1, w);
				round_field(d2, 6, g, 2, 3, w);
				f = 6 * A * A * x2 + ((6 * A * B * X) <<< FRAC)
					+ ((2 * (B * B - A * C)) <<< (2 * FRAC));
				d3 = d2 * d1;
				round_field(f, 4, d3, 9, 2, w);
				round_field(d3, 9, f, 4, 4, w);
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		curve_word_t w;
		if (done) begin
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t unexpected result word", $realtime);
			end else begin
				w = pending_words.pop_front();
				if (curve_value !== w.curve_value) report("curve_value", curve_value, w.curve_value);
				if (slope !== w.slope) report("slope", slope, w.slope);
				if (curvature !== w.curvature) report("curvature", curvature, w.curvature);
				if (inv_slope !== w.inv_slope) report("inv_slope", inv_slope, w.inv_slope);
				if (inv_curvature !== w.inv_curvature)
					report("inv_curvature", inv_curvature, w.inv_curvature);
				if (zero_div_flags !== w.zf)
					report("zero_div_flags", 32'(zero_div_flags), 32'(w.zf));
				if (saturate_flags !== w.sf)
					report("saturate_flags", 32'(saturate_flags), 32'(w.sf));
			end
		end
	end

	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fcde_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_curve(input logic [1:0] m, input logic [31:0] a, b, c, d, e);
		drain();
		write_reg(fcde_pkg::REG_MODEL, {30'h0, m});
		write_reg(fcde_pkg::REG_COEF_A, a);
		write_reg(fcde_pkg::REG_COEF_B, b);
		write_reg(fcde_pkg::REG_COEF_C, c);
		write_reg(fcde_pkg::REG_COEF_D, d);
		write_reg(fcde_pkg::REG_COEF_E, e);
		cfg_we <= 1'b0;
		cur_model = m;
		{cur_a, cur_b, cur_c, cur_d, cur_e} = {a, b, c, d, e};
	endtask

	task automatic send_pos(input logic [31:0] xv, input bit typed, input curve_word_t want);
		curve_word_t w;
		int gap;
		if (burst_left == 0)
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		start <= 1'b1;
		x_pos <= xv;
		do @(posedge clk); while (busy);
		if (typed)
			w = want;
		else
			predict_curve(xv, w);
		pending_words.push_back(w);
		burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [31:0] pick_q16();
		logic [31:0] v;
		case ($urandom_range(0, 6))
			0: v = $urandom;
			1: begin
				case ($urandom_range(0, 6))
					0: v = 32'h80000000;
					1: v = 32'h7fffffff;
					2: v = 32'h0;
					3: v = 32'h1;
					4: v = 32'hffffffff;
					5: v = 32'h00010000;
					default: v = 32'hffff0000;
				endcase
			end
			2: v = 32'($signed($urandom_range(0, 16)) - 8) << FRAC;
			3: v = $urandom_range(0, 32'h3ffff);
			default: v = $urandom_range(0, 32'hfffff);
		endcase
		if ($urandom_range(0, 1) && v != 32'h80000000)
			v = -v;
		return v;
	endfunction

	initial begin
		logic [1:0] m;
		start = 1'b0;
		x_pos = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_model = fcde_pkg::MODEL_RATIONAL;
		{cur_a, cur_b, cur_c, cur_d, cur_e} = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (DIRECTED[i].model != cur_model || DIRECTED[i].a != cur_a
					|| DIRECTED[i].b != cur_b || DIRECTED[i].c != cur_c
					|| DIRECTED[i].d != cur_d || DIRECTED[i].e != cur_e)
				load_curve(DIRECTED[i].model, DIRECTED[i].a, DIRECTED[i].b,
					DIRECTED[i].c, DIRECTED[i].d, DIRECTED[i].e);
			send_pos(DIRECTED[i].x, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int ph = 0; ph < 14; ph++) begin
			case ($urandom_range(0, 7))
				0: m = MODEL_UNUSED;
				1, 2, 3: m = fcde_pkg::MODEL_RATIONAL;
				4, 5: m = fcde_pkg::MODEL_POLY;
				default: m = fcde_pkg::MODEL_CAUCHY;
			endcase
			if (ph == 0)
				load_curve(fcde_pkg::MODEL_RATIONAL, 32'h80000000, 32'h80000000,
					32'h80000000, 32'h80000000, 32'h80000000);
			else if (ph == 1)
				load_curve(fcde_pkg::MODEL_CAUCHY, 32'h7fffffff, 32'h7fffffff,
					32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
			else
				load_curve(m, pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16());
			for (int n = 0; n < 125; n++)
				send_pos(pick_q16(), 1'b0, ZW);
		end

		drain();
		if (errors == 0 && pending_words.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/fcde_pkg.sv
rtl/core/fcde_mul.sv
rtl/core/fcde_div.sv
rtl/core/fitted_curve_derivative_evaluator_core.sv
tb/tb_top.sv
